FILE: hdl/persian_text_normalizer_top_defines.svh
// ----------------------------------------------------------------------------
// Persian text normaliser assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PERSIAN_TEXT_NORMALIZER_TOP_DEFINES_SVH
`define PERSIAN_TEXT_NORMALIZER_TOP_DEFINES_SVH

// same-cycle implication
`define PTN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ptn: same-cycle check failed");

// next-cycle implication
`define PTN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ptn: next-cycle check failed");

`endif

FILE: hdl/ptn_pkg.sv
// ----------------------------------------------------------------------------
// Persian text normaliser package
// Job record passed from front to back end, queue sizing, code constants.
// ----------------------------------------------------------------------------
package ptn_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [15:0] SPACE_UNIT = 16'h0020;
    localparam logic [15:0] PERSIAN_YEH = 16'h06CC;
    localparam logic [15:0] KEHEH       = 16'h06A9;
    localparam logic [11:0] PERSIAN_DIGIT_BASE = 12'h06F;

    // one accepted item, reduced to what the back end must emit
    typedef struct packed {
        logic        sp;      // owed space goes out first
        logic [15:0] unit;
        logic        uvalid;
        logic        last;
    } t_job;

endpackage

FILE: hdl/ptn_front.sv
// ----------------------------------------------------------------------------
// Persian text normaliser front end
// Classifies each code unit, remaps kept units and tracks the space state.
// ----------------------------------------------------------------------------
module ptn_front import ptn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_string,
    input  logic        i_lowercase,
    output logic        o_push,
    output t_job        o_job
);

    logic r_seen_text, n_seen_text;
    logic r_space_pending, n_space_pending;
    logic w_drop, w_white, w_keep;

    function automatic logic f_dropped(input logic [15:0] u);
        return (u inside {[16'h064B:16'h0652], 16'h0670, 16'h0640,
                          [16'h200C:16'h200F], [16'h202A:16'h202E],
                          [16'h2066:16'h2069], 16'hFEFF});
    endfunction

    function automatic logic f_white(input logic [15:0] u);
        return (u inside {[16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0,
                          16'h1680, [16'h2000:16'h200A], 16'h2028, 16'h2029,
                          16'h202F, 16'h205F, 16'h3000});
    endfunction

    function automatic logic [15:0] f_remap(input logic [15:0] u, input logic lower);
        logic [15:0] m;
        m = u;
        // both digit ranges start on a nibble boundary
        if (u inside {16'h064A, 16'h0649})
            m = PERSIAN_YEH;
        else if (u == 16'h0643)
            m = KEHEH;
        else if (u inside {[16'h0660:16'h0669], [16'h0030:16'h0039]})
            m = {PERSIAN_DIGIT_BASE, u[3:0]};
        else if (lower && (u inside {[16'h0041:16'h005A]}))
            m = u | 16'h0020;
        return m;
    endfunction

    assign w_drop  = f_dropped(i_code_unit);
    assign w_white = !w_drop && f_white(i_code_unit);
    assign w_keep  = !w_drop && !w_white;

    always_comb begin
        o_job.sp     = w_keep && r_space_pending;
        o_job.unit   = w_keep ? f_remap(i_code_unit, i_lowercase) : 16'h0000;
        o_job.uvalid = w_keep;
        o_job.last   = i_end_of_string;
    end

    assign o_push = i_accept && (w_keep || i_end_of_string);

    always_comb begin
        n_seen_text     = r_seen_text;
        n_space_pending = r_space_pending;
        if (i_accept) begin
            if (i_end_of_string) begin
                n_seen_text     = 1'b0;
                n_space_pending = 1'b0;
            end else if (w_keep) begin
                n_seen_text     = 1'b1;
                n_space_pending = 1'b0;
            end else if (w_white && r_seen_text) begin
                n_space_pending = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_text     <= 1'b0;
            r_space_pending <= 1'b0;
        end else begin
            r_seen_text     <= n_seen_text;
            r_space_pending <= n_space_pending;
        end
    end

endmodule

FILE: hdl/ptn_queue.sv
// ----------------------------------------------------------------------------
// Persian text normaliser job queue
// Small FIFO of jobs between front and back end.
// ----------------------------------------------------------------------------
module ptn_queue import ptn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_count, n_count;
    logic           w_push, w_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QAW'(1) : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + QAW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop)
            n_count = r_count + (QAW+1)'(1);
        else if (w_pop && !w_push)
            n_count = r_count - (QAW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wr_ptr] <= i_job;
    end

endmodule

FILE: hdl/ptn_back.sv
// ----------------------------------------------------------------------------
// Persian text normaliser back end
// Expands each job into one or two output beats through an output register.
// ----------------------------------------------------------------------------
module ptn_back import ptn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [15:0] o_out_unit,
    output logic        o_unit_valid,
    output logic        o_last_of_string
);

    logic        r_valid, n_valid;
    logic [15:0] r_unit, n_unit;
    logic        r_uvalid, n_uvalid;
    logic        r_last, n_last;
    // second beat of a space-then-unit job
    logic        r_hold, n_hold;
    logic [15:0] r_hold_unit, n_hold_unit;
    logic        r_hold_last, n_hold_last;
    logic        w_load;

    assign w_load = !r_valid || !i_stall;
    assign o_pop  = w_load && !r_hold && !i_empty;

    always_comb begin
        n_valid     = r_valid;
        n_unit      = r_unit;
        n_uvalid    = r_uvalid;
        n_last      = r_last;
        n_hold      = r_hold;
        n_hold_unit = r_hold_unit;
        n_hold_last = r_hold_last;
        if (w_load) begin
            if (r_hold) begin
                n_valid  = 1'b1;
                n_unit   = r_hold_unit;
                n_uvalid = 1'b1;
                n_last   = r_hold_last;
                n_hold   = 1'b0;
            end else if (!i_empty) begin
                n_valid = 1'b1;
                if (i_head.sp) begin
                    n_unit      = SPACE_UNIT;
                    n_uvalid    = 1'b1;
                    n_last      = 1'b0;
                    n_hold      = 1'b1;
                    n_hold_unit = i_head.unit;
                    n_hold_last = i_head.last;
                end else begin
                    n_unit   = i_head.unit;
                    n_uvalid = i_head.uvalid;
                    n_last   = i_head.last;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hold  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hold  <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit      <= n_unit;
        r_uvalid    <= n_uvalid;
        r_last      <= n_last;
        r_hold_unit <= n_hold_unit;
        r_hold_last <= n_hold_last;
    end

    assign o_valid          = r_valid;
    assign o_out_unit       = r_unit;
    assign o_unit_valid     = r_uvalid;
    assign o_last_of_string = r_last;

endmodule

FILE: hdl/persian_text_normalizer_top.sv
// ----------------------------------------------------------------------------
// Persian text normaliser top level
// Front end classifies code units, a four-job queue decouples it from the
// back end, which drives the output register.
// ----------------------------------------------------------------------------
// One code unit is taken per cycle while the job queue has room. Each item
// yields zero, one or two output beats; a kept unit that follows collapsed
// whitespace costs two beats (space, then unit), so the output register in
// the back end sets the sustained rate. A beat passes through the job queue
// and then the output register before it appears. Dropped units and
// whitespace not at end of string give no beat and cost the back end nothing.
module persian_text_normalizer_top import ptn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_lowercase_ascii_we,
    input  logic        i_lowercase_ascii,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_unit,
    output logic        o_unit_valid,
    output logic        o_last_of_string
);

`include "persian_text_normalizer_top_defines.svh"

    logic r_lowercase;
    logic w_accept, w_push, w_pop, w_full, w_empty;
    t_job w_job, w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_lowercase <= 1'b0;
        else if (i_lowercase_ascii_we)
            r_lowercase <= i_lowercase_ascii;
    end

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    ptn_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .i_lowercase     (r_lowercase),
        .o_push          (w_push),
        .o_job           (w_job)
    );

    ptn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ptn_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (w_empty),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_out_unit       (o_out_unit),
        .o_unit_valid     (o_unit_valid),
        .o_last_of_string (o_last_of_string)
    );

    // a collapsed space is never the last beat of a string
    `PTN_ASSERT_NOW(a_space_not_last, o_valid && o_out_unit == SPACE_UNIT, o_unit_valid && !o_last_of_string)
    // end marker beats carry no unit
    `PTN_ASSERT_NOW(a_marker_shape, o_valid && !o_unit_valid, o_last_of_string && o_out_unit == 16'h0000)
    // the unit owed after a space follows in the very next cycle
    `PTN_ASSERT_NEXT(a_space_then_unit, o_valid && !i_stall && o_out_unit == SPACE_UNIT, o_valid && o_unit_valid && o_out_unit != SPACE_UNIT)
    // a push is never offered to a full queue
    `PTN_ASSERT_NOW(a_no_overflow, w_full, !w_push)

endmodule

FILE: tb/persian_text_normalizer_top_tb.sv
// ----------------------------------------------------------------------------
// Persian text normaliser testbench
// Streams directed and random UTF-16 strings through the block under four
// idling profiles in both modes. Every accepted beat is checked against a
// scoreboard that tracks the owed-space and seen-text flags itself.
// ----------------------------------------------------------------------------
module persian_text_normalizer_top_tb;
    import ptn_pkg::*;

    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_PRINTED     = 100;

    // ------------------------------------------------------------------------
    // Expected-beat store and predictor of the normaliser
    // ------------------------------------------------------------------------
    class normalizer_scoreboard;
        bit          lower_mode;
        bit          seen_text;
        bit          space_owed;
        logic [17:0] expected_beats[$];   // {unit, unit_valid, last}
        int          mismatches;

        function new();
            lower_mode = 1'b0;
            seen_text  = 1'b0;
            space_owed = 1'b0;
            mismatches = 0;
        endfunction

        function bit is_dropped(logic [15:0] u);
            return (u >= 16'h064B && u <= 16'h0652) || u == 16'h0670 || u == 16'h0640 ||
                   (u >= 16'h200C && u <= 16'h200F) || (u >= 16'h202A && u <= 16'h202E) ||
                   (u >= 16'h2066 && u <= 16'h2069) || u == 16'hFEFF;
        endfunction

        function bit is_white(logic [15:0] u);
            return (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h0085 ||
                   u == 16'h00A0 || u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) ||
                   u == 16'h2028 || u == 16'h2029 || u == 16'h202F || u == 16'h205F ||
                   u == 16'h3000;
        endfunction

        function logic [15:0] fold_unit(logic [15:0] u);
            if (u == 16'h064A || u == 16'h0649) return PERSIAN_YEH;
            if (u == 16'h0643) return KEHEH;
            if (u >= 16'h0660 && u <= 16'h0669) return u - 16'h0660 + 16'h06F0;
            if (u >= 16'h0030 && u <= 16'h0039) return u - 16'h0030 + 16'h06F0;
            if (lower_mode && u >= 16'h0041 && u <= 16'h005A) return u + 16'h0020;
            return u;
        endfunction

        function void note_unit(logic [15:0] u, logic eos);
            bit          give_space;
            bit          give_unit;
            logic [15:0] unit_out;
            give_space = 1'b0;
            give_unit  = 1'b0;
            unit_out   = 16'h0000;
            if (is_dropped(u)) begin
            end else if (is_white(u)) begin
                if (seen_text) space_owed = 1'b1;
            end else begin
                give_space = space_owed;
                space_owed = 1'b0;
                give_unit  = 1'b1;
                unit_out   = fold_unit(u);
                seen_text  = 1'b1;
            end
            if (give_space) expected_beats.push_back({SPACE_UNIT, 1'b1, 1'b0});
            if (give_unit) expected_beats.push_back({unit_out, 1'b1, eos});
            else if (eos) expected_beats.push_back({16'h0000, 1'b0, 1'b1});
            // end of string: owed space is dropped, next string starts clean
            if (eos) begin
                seen_text  = 1'b0;
                space_owed = 1'b0;
            end
        endfunction

        function int outstanding();
            return expected_beats.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_beat(logic [15:0] unit, logic uv, logic last);
            logic [17:0] want;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat unit=%h uv=%b last=%b",
                                          unit, uv, last));
            end else begin
                want = expected_beats.pop_front();
                if (unit !== want[17:2])
                    report_mismatch($sformatf("out_unit %h, want %h", unit, want[17:2]));
                if (uv !== want[1])
                    report_mismatch($sformatf("unit_valid %b, want %b (unit %h)",
                                              uv, want[1], want[17:2]));
                if (last !== want[0])
                    report_mismatch($sformatf("last_of_string %b, want %b (unit %h)",
                                              last, want[0], want[17:2]));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n              = 1'b0;
    logic        i_lowercase_ascii_we = 1'b0;
    logic        i_lowercase_ascii    = 1'b0;
    logic        i_valid              = 1'b0;
    logic [15:0] i_code_unit          = 16'h0000;
    logic        i_end_of_string      = 1'b0;
    logic        i_stall              = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_out_unit;
    logic        o_unit_valid;
    logic        o_last_of_string;

    normalizer_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;

    persian_text_normalizer_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_lowercase_ascii_we(i_lowercase_ascii_we),
        .i_lowercase_ascii   (i_lowercase_ascii),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_code_unit         (i_code_unit),
        .i_end_of_string     (i_end_of_string),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_out_unit          (o_out_unit),
        .o_unit_valid        (o_unit_valid),
        .o_last_of_string    (o_last_of_string)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // beats on both channels, sampled at the edge that accepts them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_beat(o_out_unit, o_unit_valid, o_last_of_string);
            if (i_valid && !o_stall) sb.note_unit(i_code_unit, i_end_of_string);
        end
    end

    task automatic send_unit(input logic [15:0] u, input logic eos);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_code_unit     <= u;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_mode(input logic m);
        i_lowercase_ascii_we <= 1'b1;
        i_lowercase_ascii    <= m;
        @(posedge i_clk);
        i_lowercase_ascii_we <= 1'b0;
        sb.lower_mode = m;
    endtask

    // dropped units leave no beat, so allow the pipe to empty past the last one
    task automatic drain();
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_white();
        case ($urandom_range(0, 9))
            0:       return 16'h0009 + 16'($urandom_range(0, 4));
            1:       return 16'h0020;
            2:       return 16'h0085;
            3:       return 16'h00A0;
            4:       return 16'h1680;
            5:       return 16'h2000 + 16'($urandom_range(0, 10));
            6:       return 16'h2028 + 16'($urandom_range(0, 1));
            7:       return 16'h202F;
            8:       return 16'h205F;
            default: return 16'h3000;
        endcase
    endfunction

    function automatic logic [15:0] pick_dropped();
        case ($urandom_range(0, 6))
            0:       return 16'h064B + 16'($urandom_range(0, 7));
            1:       return 16'h0670;
            2:       return 16'h0640;
            3:       return 16'h200C + 16'($urandom_range(0, 3));
            4:       return 16'h202A + 16'($urandom_range(0, 4));
            5:       return 16'h2066 + 16'($urandom_range(0, 3));
            default: return 16'hFEFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_code_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return 16'h0600 + 16'($urandom_range(0, 255));
        if (pick < 45) return pick_white();
        if (pick < 55) return pick_dropped();
        if (pick < 65) begin
            case ($urandom_range(0, 4))
                0:       return 16'h064A;
                1:       return 16'h0649;
                2:       return 16'h0643;
                3:       return 16'h0660 + 16'($urandom_range(0, 9));
                default: return 16'h0030 + 16'($urandom_range(0, 9));
            endcase
        end
        if (pick < 80) return 16'($urandom_range(16'h0020, 16'h007E));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic directed_plain();
        send_unit(16'h0020, 1'b0);   // leading space, nothing owed
        send_unit(16'h0000, 1'b0);
        send_unit(16'h3000, 1'b0);
        send_unit(16'h064B, 1'b0);
        send_unit(16'h0041, 1'b0);   // space then unit
        send_unit(16'h000D, 1'b1);   // trailing space discarded
        send_unit(16'h0640, 1'b1);   // lone dropped unit ends string
        send_unit(16'h064A, 1'b0);
        send_unit(16'h0649, 1'b0);
        send_unit(16'h0643, 1'b0);
        send_unit(16'h0660, 1'b0);
        send_unit(16'h0669, 1'b0);
        send_unit(16'h0030, 1'b0);
        send_unit(16'h0039, 1'b0);
        send_unit(16'h200F, 1'b0);
        send_unit(16'h00A0, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hFEFF, 1'b1);
    endtask

    task automatic directed_search();
        send_unit(16'h0040, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h005A, 1'b0);
        send_unit(16'h005B, 1'b0);
        send_unit(16'h0061, 1'b1);
    endtask

    task automatic random_strings(input int target);
        int sent;
        int len;
        int k;
        bit broken;
        sent = 0;
        while (sent < target) begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 14);
            broken = ($urandom_range(0, 9) == 0);
            for (k = 0; k < len; k++) begin
                // filler-only strings end with nothing kept
                if (broken)
                    send_unit($urandom_range(0, 1) ? pick_white() : pick_dropped(),
                              1'(k == len - 1));
                else
                    send_unit(rand_code_unit(), 1'(k == len - 1));
                sent++;
            end
        end
    endtask

    initial begin
        int phase;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase >> 1)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            if (phase == 0) directed_plain();
            if (phase == 1) directed_search();
            random_strings(ITEMS_PER_PHASE);
            i_valid <= 1'b0;
            drain();
            if (phase < NUM_PHASES - 1) write_mode(1'((phase + 1) % 2));
        end
        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d beats never arrived", sb.outstanding()));
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
